>>> hdl/rga_sequence_table_assert.svh
// Assertion macros for the sequence table checker.
`ifndef RGA_SEQUENCE_TABLE_ASSERT_SVH
`define RGA_SEQUENCE_TABLE_ASSERT_SVH

// Consequent in the same cycle.
`define RGA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the next cycle.
`define RGA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rga_pkg.sv
package rga_pkg;

   typedef logic [47:0] id_type;

   // One table slot as it travels round the ring of cells.
   typedef struct packed {
      id_type      id;
      id_type      parent;
      logic [15:0] chr;
      logic        deleted;
      logic        mark;
   } slot_type;

   // Ring control from the sequencer to the cells.
   typedef struct packed {
      logic     shift;
      slot_type feed;
   } ring_ctl_type;

   typedef enum logic [1:0] {
      KIND_INSERT,
      KIND_REMOVE,
      KIND_QUERY,
      KIND_CLEAR
   } kind_type;

   typedef enum logic [2:0] {
      ST_DONE,
      ST_DUPLICATE,
      ST_NOT_FOUND,
      ST_FULL,
      ST_RANGE
   } status_type;

endpackage

>>> hdl/rga_cell.sv
module rga_cell
   import rga_pkg::*;
(
   input  logic     clock,
   input  logic     shift,
   input  slot_type from_next,
   output slot_type slot_out
);

   slot_type slot_ff;

   // Take the neighbour's slot on every ring step.
   always_ff @(posedge clock) begin
      if (shift) begin
         slot_ff <= from_next;
      end
   end

   assign slot_out = slot_ff;

endmodule

>>> hdl/rga_ctrl.sv
module rga_ctrl
   import rga_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  kind_type     req_kind,
   input  id_type       req_id,
   input  id_type       req_parent,
   input  logic [15:0]  req_char,
   input  logic [12:0]  req_position,
   input  slot_type     head,
   output ring_ctl_type ring,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output status_type   rsp_status,
   output id_type       rsp_found,
   output logic [12:0]  rsp_length
);

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 13) ? CW : 13;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_FDEC,
      S_CHECK,
      S_CDEC,
      S_SHIFT,
      S_RESP
   } state_type;

   state_type   state_ff;
   logic [IW-1:0] k_ff;
   kind_type    kind_ff;
   id_type      id_ff, par_ff, fid_ff, found_ff;
   id_type      cand_id_ff, cand_par_ff;
   logic [15:0] chr_ff;
   logic [11:0] pos_ff;
   logic [CW-1:0] used_ff, live_ff, at_ff, seen_ff;
   logic        hit_ff, skip_ff, match_ff, pfound_ff, capnext_ff;
   slot_type    buf_ff;
   status_type  status_ff;
   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   id_type      rsp_found_ff;
   logic [12:0] rsp_length_ff;

   logic [CW-1:0] k_ext, at_inc, new_at;
   logic          in_use, last, par_root, skip_now, id_hit, seen_hit;
   slot_type      new_slot;

   assign k_ext    = CW'(k_ff);
   assign in_use   = k_ext < used_ff;
   assign last     = k_ff == IW'(DEPTH - 1);
   assign par_root = par_ff == '0;
   assign skip_now = (cand_par_ff == par_ff) ? (cand_id_ff > id_ff) : hit_ff;
   assign id_hit   = in_use && (head.id == id_ff) && !match_ff;
   assign seen_hit = CMPW'(seen_ff) == CMPW'(pos_ff);
   assign at_inc   = at_ff + CW'(1);
   assign new_at   = par_root ? '0 : at_ff;
   assign new_slot = '{id: id_ff, parent: par_ff, chr: chr_ff, deleted: 1'b0, mark: 1'b0};

   // Ring feed: write back the head, edited where the pass needs it.
   always_comb begin
      ring.shift = (state_ff == S_FIND) || (state_ff == S_CHECK) || (state_ff == S_SHIFT);
      ring.feed  = head;
      case (state_ff)
         S_FIND: begin
            if (kind_ff == KIND_INSERT) ring.feed.mark = 1'b0;
            if (kind_ff == KIND_REMOVE && id_hit) ring.feed.deleted = 1'b1;
         end
         S_CHECK: begin
            if (k_ext == at_ff) ring.feed.mark = skip_now;
         end
         S_SHIFT: begin
            if (k_ext == at_ff) ring.feed = new_slot;
            else if (k_ext > at_ff) ring.feed = buf_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the taken result; the result state reloads it itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESP) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff    <= req_kind;
                  id_ff      <= req_id;
                  par_ff     <= req_parent;
                  chr_ff     <= req_char;
                  pos_ff     <= req_position[11:0];
                  k_ff       <= '0;
                  match_ff   <= 1'b0;
                  pfound_ff  <= 1'b0;
                  capnext_ff <= 1'b0;
                  seen_ff    <= '0;
                  hit_ff     <= 1'b0;
                  found_ff   <= '0;
                  case (req_kind)
                     KIND_CLEAR: begin
                        used_ff   <= '0;
                        live_ff   <= '0;
                        status_ff <= ST_DONE;
                        state_ff  <= S_RESP;
                     end
                     KIND_QUERY: begin
                        if (req_position[12]) begin
                           status_ff <= ST_DONE;
                           state_ff  <= S_RESP;
                        end else begin
                           state_ff <= S_FIND;
                        end
                     end
                     default: state_ff <= S_FIND;
                  endcase
               end
            end
            S_FIND: begin
               k_ff <= last ? '0 : k_ff + IW'(1);
               case (kind_ff)
                  KIND_INSERT: begin
                     if (id_hit) match_ff <= 1'b1;
                     if (in_use && !par_root && !pfound_ff && head.id == par_ff) begin
                        pfound_ff  <= 1'b1;
                        at_ff      <= k_ext + CW'(1);
                        capnext_ff <= 1'b1;
                     end
                     if (capnext_ff || (par_root && k_ff == '0)) begin
                        cand_id_ff  <= head.id;
                        cand_par_ff <= head.parent;
                        capnext_ff  <= 1'b0;
                     end
                  end
                  KIND_REMOVE: begin
                     if (id_hit) begin
                        match_ff <= 1'b1;
                        if (!head.deleted) live_ff <= live_ff - CW'(1);
                     end
                  end
                  KIND_QUERY: begin
                     if (in_use && !head.deleted && !match_ff) begin
                        if (seen_hit) begin
                           match_ff <= 1'b1;
                           fid_ff   <= head.id;
                        end
                        seen_ff <= seen_ff + CW'(1);
                     end
                  end
                  default: ;
               endcase
               if (last) state_ff <= S_FDEC;
            end
            S_FDEC: begin
               case (kind_ff)
                  KIND_INSERT: begin
                     if (match_ff) begin
                        status_ff <= ST_DUPLICATE;
                        state_ff  <= S_RESP;
                     end else if (!par_root && !pfound_ff) begin
                        status_ff <= ST_NOT_FOUND;
                        state_ff  <= S_RESP;
                     end else if (used_ff == CW'(DEPTH)) begin
                        status_ff <= ST_FULL;
                        state_ff  <= S_RESP;
                     end else begin
                        at_ff    <= new_at;
                        hit_ff   <= 1'b0;
                        state_ff <= (new_at < used_ff) ? S_CHECK : S_SHIFT;
                     end
                  end
                  KIND_REMOVE: begin
                     status_ff <= match_ff ? ST_DONE : ST_NOT_FOUND;
                     state_ff  <= S_RESP;
                  end
                  KIND_QUERY: begin
                     status_ff <= match_ff ? ST_DONE : ST_RANGE;
                     found_ff  <= match_ff ? fid_ff : '0;
                     state_ff  <= S_RESP;
                  end
                  default: state_ff <= S_RESP;
               endcase
            end
            S_CHECK: begin
               k_ff <= last ? '0 : k_ff + IW'(1);
               if (k_ext < at_ff && head.mark && head.id == cand_par_ff) hit_ff <= 1'b1;
               if (k_ext == at_ff) skip_ff <= skip_now;
               if (k_ext == at_inc) begin
                  cand_id_ff  <= head.id;
                  cand_par_ff <= head.parent;
               end
               if (last) state_ff <= S_CDEC;
            end
            S_CDEC: begin
               hit_ff <= 1'b0;
               if (skip_ff) begin
                  at_ff    <= at_inc;
                  state_ff <= (at_inc < used_ff) ? S_CHECK : S_SHIFT;
               end else begin
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               k_ff <= last ? '0 : k_ff + IW'(1);
               if (k_ext >= at_ff) buf_ff <= head;
               if (last) begin
                  used_ff   <= used_ff + CW'(1);
                  live_ff   <= live_ff + CW'(1);
                  status_ff <= ST_DONE;
                  state_ff  <= S_RESP;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_found_ff  <= found_ff;
                  rsp_length_ff <= 13'(live_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready  = state_ff == S_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_length = rsp_length_ff;

endmodule

>>> hdl/rga_sequence_table.sv
// Clear and negative position query go straight to the result register.
// Remove and position query: one ring pass, a decision state, then the result register.
// Insert: a search pass, a test pass for each slot tested for skipping, then the
// shift pass and the result register; rejected inserts end after the search pass.
// Throughput: one item at a time, set by the ring of DEPTH cells rotating once a pass.
// Reset (synchronous, active high) empties the table and drops any pending result.
module rga_sequence_table
   import rga_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // id_time[31:0], id_site[47:32], parent_time[79:48], parent_site[95:80],
   // char_value[111:96], position[124:112], zero pad[127:125]
   input  logic [127:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], found_time[34:3], found_site[50:35], visible_length[63:51]
   output logic [63:0]  rsp_tdata
);

   // The table lives in a ring of cells; cell 0 is the head the sequencer
   // looks at, and the last cell takes the sequencer's feed. One full pass
   // of DEPTH steps brings every slot past the head in order and leaves the
   // ring aligned again, slot k back in cell k.
   slot_type     slots [DEPTH];
   ring_ctl_type ring;
   status_type   rsp_status;
   id_type       rsp_found;
   logic [12:0]  rsp_length;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_tail
         rga_cell u_cell (
            .clock     (clock),
            .shift     (ring.shift),
            .from_next (ring.feed),
            .slot_out  (slots[i])
         );
      end else begin : g_body
         rga_cell u_cell (
            .clock     (clock),
            .shift     (ring.shift),
            .from_next (slots[i+1]),
            .slot_out  (slots[i])
         );
      end
   end

   // Sequencer: search, skip test and shift passes, result register.
   rga_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (kind_type'(req_tuser)),
      .req_id       ({req_tdata[31:0], req_tdata[47:32]}),
      .req_parent   ({req_tdata[79:48], req_tdata[95:80]}),
      .req_char     (req_tdata[111:96]),
      .req_position (req_tdata[124:112]),
      .head         (slots[0]),
      .ring         (ring),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_length   (rsp_length)
   );

   // Pack the result transfer.
   assign rsp_tdata = {rsp_length, rsp_found[15:0], rsp_found[47:16], 3'(rsp_status)};

endmodule

>>> hdl/rga_checker.sv
`include "rga_sequence_table_assert.svh"

module rga_checker
   import rga_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata
);

   `RGA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `RGA_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "accepted a transfer while busy")
   `RGA_ASSERT_SAME(a_found_only_done, rsp_tvalid && rsp_tdata[2:0] != 3'(ST_DONE), rsp_tdata[50:3] == 48'd0, "id returned with failing status")
   `RGA_ASSERT_SAME(a_status_code, rsp_tvalid, rsp_tdata[2:0] <= 3'(ST_RANGE), "status code out of range")

endmodule

bind rga_sequence_table rga_checker u_checker (.*);
